FILE: rtl/core/windowed_running_variance_top_macros.svh
// Assertion macros shared by the windowed running variance RTL.
`ifndef WINDOWED_RUNNING_VARIANCE_TOP_MACROS_SVH
`define WINDOWED_RUNNING_VARIANCE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising clock edge out of reset.
`define WRV_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define WRV_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");
`else
`define WRV_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define WRV_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

FILE: rtl/core/wrv_pkg.sv
// Shared types, constants and the microcode program of the windowed running variance block.
package wrv_pkg;

   // Field widths and packed channel widths.
   localparam int WRV_MAX_WINDOW = 1024;
   localparam int SAMPLE_W       = 32;
   localparam int COUNT_W        = 11;
   localparam int TIME_W         = 48;
   localparam int M2_W           = 64;
   localparam int REQ_DATA_W     = 96;
   localparam int RSP_DATA_W     = 160;
   localparam int DIV_STEPS      = 32;
   localparam int LOOP_W         = $clog2(DIV_STEPS);

   // Opcode of a request.
   localparam logic OPC_REMOVE = 1'b0;
   localparam logic OPC_ADD    = 1'b1;

   // Datapath operation selected by a control word.
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_PREP,
      OP_DIV,
      OP_MEAN,
      OP_MUL,
      OP_PROD,
      OP_UPD,
      OP_CLEAR
   } op_type;

   // How the step counter advances after a control word.
   typedef enum logic [1:0] {
      COND_NEXT,
      COND_GOTO,
      COND_IF_ZERO,
      COND_LOOP
   } cond_type;

   typedef logic [2:0] step_type;

   // Program step addresses.
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_PREP  = 3'd1;
   localparam step_type STEP_DIV   = 3'd2;
   localparam step_type STEP_MEAN  = 3'd3;
   localparam step_type STEP_MUL   = 3'd4;
   localparam step_type STEP_PROD  = 3'd5;
   localparam step_type STEP_UPD   = 3'd6;
   localparam step_type STEP_CLEAR = 3'd7;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Datapath conditions seen by the sequencer.
   typedef struct packed {
      logic hold;
      logic n_zero;
      logic loop_zero;
   } status_type;

   // Microcode program: one control word per step.
   function automatic ctrl_word_type wrv_rom(input step_type step);
      ctrl_word_type word;
      case (step)
         STEP_IDLE:  word = '{op: OP_IDLE,  cond: COND_NEXT,    target: STEP_IDLE};
         STEP_PREP:  word = '{op: OP_PREP,  cond: COND_IF_ZERO, target: STEP_CLEAR};
         STEP_DIV:   word = '{op: OP_DIV,   cond: COND_LOOP,    target: STEP_DIV};
         STEP_MEAN:  word = '{op: OP_MEAN,  cond: COND_NEXT,    target: STEP_IDLE};
         STEP_MUL:   word = '{op: OP_MUL,   cond: COND_NEXT,    target: STEP_IDLE};
         STEP_PROD:  word = '{op: OP_PROD,  cond: COND_NEXT,    target: STEP_IDLE};
         STEP_UPD:   word = '{op: OP_UPD,   cond: COND_GOTO,    target: STEP_IDLE};
         STEP_CLEAR: word = '{op: OP_CLEAR, cond: COND_GOTO,    target: STEP_IDLE};
         default:    word = '{op: OP_IDLE,  cond: COND_GOTO,    target: STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

FILE: rtl/core/wrv_seq.sv
// Microcode sequencer: step counter, program table and jump logic.
module wrv_seq
   import wrv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  status_type    status,
   output ctrl_word_type ctrl
);

   step_type step_ff;
   step_type step_in;

   // Current control word straight from the program table.
   assign ctrl = wrv_rom(step_ff);

   // Next step: hold, fall through, or jump on a datapath condition.
   always_comb begin
      step_in = step_ff + 3'd1;
      if (status.hold) begin
         step_in = step_ff;
      end else begin
         case (ctrl.cond)
            COND_NEXT:    step_in = step_ff + 3'd1;
            COND_GOTO:    step_in = ctrl.target;
            COND_IF_ZERO: step_in = status.n_zero ? ctrl.target : step_ff + 3'd1;
            COND_LOOP:    step_in = status.loop_zero ? step_ff + 3'd1 : ctrl.target;
            default:      step_in = STEP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: rtl/core/wrv_datapath.sv
// Datapath: request capture, shift-subtract divider, multiplier, state and result register.
module wrv_datapath
   import wrv_pkg::*;
#(
   parameter int MAX_WINDOW = WRV_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_word_type         ctrl,
   output status_type            status,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser
);

   // Latched request.
   logic                add_ff, add_in;
   logic [SAMPLE_W-1:0] x_ff, x_in;
   logic [COUNT_W-1:0]  n_ff, n_in;
   logic [TIME_W-1:0]   ts_ff, ts_in;

   // Window state.
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [M2_W-1:0]     m2_ff, m2_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0]   time_ff, time_in;

   // Working registers.
   logic [SAMPLE_W-1:0] dmag_ff, dmag_in;
   logic                d_neg_ff, d_neg_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [LOOP_W-1:0]   loop_ff, loop_in;
   logic [SAMPLE_W-1:0] nm_ff, nm_in;
   logic [SAMPLE_W-1:0] emag_ff, emag_in;
   logic                e_neg_ff, e_neg_in;
   logic [M2_W-1:0]     prod_ff, prod_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                  out_busy;
   logic                  commit;
   logic                  start;
   logic [COUNT_W-1:0]    n_raw;
   logic [SAMPLE_W:0]     d_w;
   logic [COUNT_W:0]      shifted;
   logic [COUNT_W:0]      diff;
   logic                  ge;
   logic [SAMPLE_W+1:0]   q_w;
   logic [SAMPLE_W+1:0]   nm_w;
   logic [SAMPLE_W-1:0]   nm_sat;
   logic [SAMPLE_W:0]     e_w;
   logic [M2_W:0]         sum_w;
   logic                  m2_neg;
   logic                  sat;
   logic [M2_W-1:0]       m2_upd;

   // Handshake and sequencer status.
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign req_tready = (ctrl.op == OP_IDLE);
   assign start      = req_tvalid && req_tready;
   assign commit     = ((ctrl.op == OP_UPD) || (ctrl.op == OP_CLEAR)) && !out_busy;

   always_comb begin
      status.hold      = ((ctrl.op == OP_IDLE) && !req_tvalid)
                      || (((ctrl.op == OP_UPD) || (ctrl.op == OP_CLEAR)) && out_busy);
      status.n_zero    = (n_ff == '0);
      status.loop_zero = (loop_ff == '0);
   end

   // Divisor field of the request; the idle step clamps it against the window limit.
   assign n_raw = req_tdata[SAMPLE_W +: COUNT_W];

   // Deviation of the sample from the old mean, sign extended by one bit.
   assign d_w = {x_ff[SAMPLE_W-1], x_ff} - {mean_ff[SAMPLE_W-1], mean_ff};

   // One restoring division step.
   assign shifted = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign diff    = shifted - {1'b0, n_ff};
   assign ge      = (shifted >= {1'b0, n_ff});

   // New mean with saturation to the Q16.16 range.
   always_comb begin
      q_w = {2'b00, quo_ff};
      if (d_neg_ff) begin
         q_w = -q_w;
      end
      if (add_ff == OPC_ADD) begin
         nm_w = {{2{mean_ff[SAMPLE_W-1]}}, mean_ff} + q_w;
      end else begin
         nm_w = {{2{mean_ff[SAMPLE_W-1]}}, mean_ff} - q_w;
      end
      if ((nm_w[SAMPLE_W+1:SAMPLE_W-1] == 3'b000) || (nm_w[SAMPLE_W+1:SAMPLE_W-1] == 3'b111)) begin
         nm_sat = nm_w[SAMPLE_W-1:0];
      end else if (nm_w[SAMPLE_W+1]) begin
         nm_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         nm_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   assign e_w = {x_ff[SAMPLE_W-1], x_ff} - {nm_ff[SAMPLE_W-1], nm_ff};

   // M2 update: add or subtract the product, clamping at zero and all ones.
   assign sum_w  = {1'b0, m2_ff} + {1'b0, prod_ff};
   assign m2_neg = d_neg_ff ^ e_neg_ff ^ (add_ff != OPC_ADD);

   always_comb begin
      sat    = 1'b0;
      m2_upd = m2_ff;
      if (prod_ff == '0) begin
         m2_upd = m2_ff;
      end else if (!m2_neg) begin
         if (sum_w[M2_W]) begin
            m2_upd = '1;
            sat    = 1'b1;
         end else begin
            m2_upd = sum_w[M2_W-1:0];
         end
      end else begin
         if (prod_ff > m2_ff) begin
            m2_upd = '0;
            sat    = 1'b1;
         end else begin
            m2_upd = m2_ff - prod_ff;
         end
      end
   end

   // Operation decode.
   always_comb begin
      add_in   = add_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      ts_in    = ts_ff;
      mean_in  = mean_ff;
      m2_in    = m2_ff;
      count_in = count_ff;
      time_in  = time_ff;
      dmag_in  = dmag_ff;
      d_neg_in = d_neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      loop_in  = loop_ff;
      nm_in    = nm_ff;
      emag_in  = emag_ff;
      e_neg_in = e_neg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_sat_in  = rsp_sat_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (ctrl.op)
         OP_IDLE: begin
            if (start) begin
               add_in = req_tuser[0];
               x_in   = req_tdata[SAMPLE_W-1:0];
               ts_in  = req_tdata[SAMPLE_W+COUNT_W +: TIME_W];
               if ({21'd0, n_raw} > 32'(MAX_WINDOW)) begin
                  n_in = COUNT_W'(MAX_WINDOW);
               end else begin
                  n_in = n_raw;
               end
            end
         end
         OP_PREP: begin
            d_neg_in = d_w[SAMPLE_W];
            dmag_in  = d_w[SAMPLE_W] ? SAMPLE_W'(-d_w) : d_w[SAMPLE_W-1:0];
            quo_in   = d_w[SAMPLE_W] ? SAMPLE_W'(-d_w) : d_w[SAMPLE_W-1:0];
            rem_in   = '0;
            loop_in  = LOOP_W'(DIV_STEPS - 1);
         end
         OP_DIV: begin
            rem_in  = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            quo_in  = {quo_ff[SAMPLE_W-2:0], ge};
            loop_in = loop_ff - 1'b1;
         end
         OP_MEAN: begin
            nm_in = nm_sat;
         end
         OP_MUL: begin
            e_neg_in = e_w[SAMPLE_W];
            emag_in  = e_w[SAMPLE_W] ? SAMPLE_W'(-e_w) : e_w[SAMPLE_W-1:0];
         end
         OP_PROD: begin
            // The product register is loaded in its own block.
         end
         OP_UPD: begin
            if (commit) begin
               mean_in  = nm_ff;
               m2_in    = m2_upd;
               count_in = n_ff;
               time_in  = (add_ff == OPC_ADD) ? ts_ff : time_ff;
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sat;
               rsp_data_in  = {5'd0, time_in, count_in, m2_in, mean_in};
            end
         end
         OP_CLEAR: begin
            if (commit) begin
               mean_in  = '0;
               m2_in    = '0;
               count_in = n_ff;
               time_in  = (add_ff == OPC_ADD) ? ts_ff : time_ff;
               rsp_valid_in = 1'b1;
               rsp_sat_in   = 1'b0;
               rsp_data_in  = {5'd0, time_in, count_in, m2_in, mean_in};
            end
         end
         default: begin
            // Any other step leaves the state alone.
         end
      endcase
   end

   // The multiplier runs in its own step, after the magnitude of e is registered.
   always_comb begin
      prod_in = prod_ff;
      if (ctrl.op == OP_PROD) begin
         prod_in = {{(M2_W-SAMPLE_W){1'b0}}, dmag_ff} * {{(M2_W-SAMPLE_W){1'b0}}, emag_ff};
      end
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff      <= '0;
         m2_ff        <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         loop_ff      <= '0;
      end else begin
         mean_ff      <= mean_in;
         m2_ff        <= m2_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         loop_ff      <= loop_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      add_ff      <= add_in;
      x_ff        <= x_in;
      n_ff        <= n_in;
      ts_ff       <= ts_in;
      dmag_ff     <= dmag_in;
      d_neg_ff    <= d_neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      nm_ff       <= nm_in;
      emag_ff     <= emag_in;
      e_neg_ff    <= e_neg_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

FILE: rtl/core/windowed_running_variance_top.sv
// Top level of the windowed running variance block: sequencer, datapath and checks.
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------------------
//  req_    | in        | tuser: opcode; tdata: sample, window_count, timestamp
//  rsp_    | out       | tuser: saturated; tdata: mean, sum_sq_dev, count, last_time
//
// A request with a nonzero count runs through these steps from acceptance to the next acceptance:
// one preparation step, 32 steps of the one-bit-per-cycle divider, then mean, multiply,
// product and update steps, and a return to the idle step. A zero count goes from preparation to the clear step.
// Reset clears the mean, M2, count and timestamp and empties the result register.
// A new request is accepted while a finished result still waits; the update or clear step
// holds only while the result register is full and rsp_tready is low.
`include "windowed_running_variance_top_macros.svh"

module windowed_running_variance_top
   import wrv_pkg::*;
#(
   parameter int MAX_WINDOW = WRV_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] sample, [42:32] window_count, [90:43] timestamp, [95:91] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] mean, [95:32] sum_sq_dev, [106:96] count, [154:107] last_time, [159:155] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] saturated
   output logic [0:0]            rsp_tuser
);

   ctrl_word_type      ctrl;
   status_type         status;
   logic [M2_W-1:0]    rsp_m2;
   logic [COUNT_W-1:0] rsp_count;

   // Program sequencer.
   wrv_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Arithmetic datapath and window state.
   wrv_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Result fields watched by the checks.
   assign rsp_m2    = rsp_tdata[95:32];
   assign rsp_count = rsp_tdata[106:96];

   // The block is not ready in the cycle after it takes a request.
   `WRV_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // A saturation flag leaves M2 at one of its two limits.
   `WRV_ASSERT_IMPLIES(a_sat_at_limit, clock, reset, rsp_tvalid && rsp_tuser[0], (rsp_m2 == '0) || (rsp_m2 == '1))

   // The reported count never exceeds the window limit.
   `WRV_ASSERT_IMPLIES(a_count_limit, clock, reset, rsp_tvalid, {21'd0, rsp_count} <= 32'(MAX_WINDOW))

endmodule
